>>> src/keystroke_inject_queue_top_macros.svh
// Assertion macros shared by the keystroke injection queue RTL.
// Included by the top level; depends on nothing else.
`ifndef KEYSTROKE_INJECT_QUEUE_TOP_MACROS_SVH
`define KEYSTROKE_INJECT_QUEUE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KIQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keystroke queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define KIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keystroke queue check failed");

`endif

>>> src/kiq_pkg.sv
// Package for the keystroke injection queue: sizes, codes, result type and key ROM.
// Used by the top level, kiq_out_skid and the testbench; depends on nothing.
`default_nettype none

package kiq_pkg;

    localparam int QUEUE_DEPTH = 4096;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 6;
    localparam int FRAME_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_FRAMES  = 1'b1;

    localparam logic [FRAME_W-1:0] HOLD_FRAMES_RESET = 8'd3;
    localparam logic [FRAME_W-1:0] GAP_FRAMES_RESET  = 8'd1;

    // Input word kinds carried in tuser.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Dense key codes: the letter and digit bases, then the keys beyond them.
    localparam logic [CODE_W-1:0] KC_A      = 6'd0;
    localparam logic [CODE_W-1:0] KC_0      = 6'd26;
    localparam logic [CODE_W-1:0] KC_6      = 6'd32;
    localparam logic [CODE_W-1:0] KC_RETURN = 6'd36;
    localparam logic [CODE_W-1:0] KC_ESC    = 6'd37;
    localparam logic [CODE_W-1:0] KC_DEL    = 6'd38;
    localparam logic [CODE_W-1:0] KC_BLANK  = 6'd39;
    localparam logic [CODE_W-1:0] KC_DASH   = 6'd40;
    localparam logic [CODE_W-1:0] KC_COMMA  = 6'd41;
    localparam logic [CODE_W-1:0] KC_PERIOD = 6'd42;
    localparam logic [CODE_W-1:0] KC_SLASH  = 6'd43;
    localparam logic [CODE_W-1:0] KC_COLON  = 6'd44;
    localparam logic [CODE_W-1:0] KC_SEMI   = 6'd45;

    // One result word; key_held sits in the lowest bit.
    typedef struct packed {
        logic              dropped;
        logic              shift_held;
        logic [CODE_W-1:0] key_code;
        logic              key_held;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic              shift;
        logic [CODE_W-1:0] code;
    } key_map_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic key_map_t key_rom(input logic [BYTE_W-1:0] c);
        key_map_t m;
        m = '0;
        priority if (c >= 8'h41 && c <= 8'h5a)
        begin
            m = '{valid: 1'b1, shift: 1'b0, code: KC_A + CODE_W'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7a)
        begin
            m = '{valid: 1'b1, shift: 1'b1, code: KC_A + CODE_W'(c - 8'h61)};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            m = '{valid: 1'b1, shift: 1'b0, code: KC_0 + CODE_W'(c - 8'h30)};
        end
        else if (c >= 8'h21 && c <= 8'h29)
        begin
            // Shifted digit row: the symbol sits over the digit one place up.
            m = '{valid: 1'b1, shift: 1'b1, code: KC_0 + CODE_W'(c - 8'h20)};
        end
        else
        begin
            unique case (c)
                8'h0a, 8'h0d: m = '{valid: 1'b1, shift: 1'b0, code: KC_RETURN};
                8'h1b:        m = '{valid: 1'b1, shift: 1'b0, code: KC_ESC};
                8'h7f:        m = '{valid: 1'b1, shift: 1'b0, code: KC_DEL};
                8'h20:        m = '{valid: 1'b1, shift: 1'b0, code: KC_BLANK};
                8'h2d:        m = '{valid: 1'b1, shift: 1'b0, code: KC_DASH};
                8'h3d:        m = '{valid: 1'b1, shift: 1'b1, code: KC_DASH};
                8'h2c:        m = '{valid: 1'b1, shift: 1'b0, code: KC_COMMA};
                8'h3c:        m = '{valid: 1'b1, shift: 1'b1, code: KC_COMMA};
                8'h2e:        m = '{valid: 1'b1, shift: 1'b0, code: KC_PERIOD};
                8'h3e:        m = '{valid: 1'b1, shift: 1'b1, code: KC_PERIOD};
                8'h2f:        m = '{valid: 1'b1, shift: 1'b0, code: KC_SLASH};
                8'h3f:        m = '{valid: 1'b1, shift: 1'b1, code: KC_SLASH};
                8'h3a:        m = '{valid: 1'b1, shift: 1'b0, code: KC_COLON};
                8'h2a:        m = '{valid: 1'b1, shift: 1'b1, code: KC_COLON};
                8'h3b:        m = '{valid: 1'b1, shift: 1'b0, code: KC_SEMI};
                8'h2b:        m = '{valid: 1'b1, shift: 1'b1, code: KC_SEMI};
                8'h5e:        m = '{valid: 1'b1, shift: 1'b1, code: KC_6};
                default:      m = '0;
            endcase
        end
        key_rom = m;
    endfunction

endpackage

`default_nettype wire

>>> src/kiq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module kiq_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the contents before a write in the same cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/kiq_out_skid.sv
// Two-entry result buffer: output register plus skid register.
// Depends on kiq_pkg for the result type.
`default_nettype none

module kiq_out_skid (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire kiq_pkg::result_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output kiq_pkg::result_t     out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    kiq_pkg::result_t out_data_reg, out_data_next;
    kiq_pkg::result_t skid_data_reg, skid_data_next;
    logic             in_take;

    // Ready is registered: only a full skid stage blocks the producer.
    assign in_ready  = !skid_valid_reg;
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_take;
                out_data_next  = in_data;
            end
        end
        else if (in_take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

>>> src/keystroke_inject_queue_top.sv
// Keystroke injection queue: byte FIFO, frame timers and key ROM lookup.
// Depends on kiq_pkg, kiq_ram, kiq_out_skid and keystroke_inject_queue_top_macros.svh.
//
//   Channel | Direction | Word contents (lowest bit first)
//   s_*     | in        | tdata: byte_in[7:0]; tuser: op (0 push, 1 frame tick)
//   m_*     | out       | tdata: key_held, key_code[5:0], shift_held, dropped, zero fill
//   cfg_*   | in        | index 0 hold_frames, index 1 gap_frames, 8-bit data
//
// Every input word is fully handled in the cycle it is accepted, so the block
// takes one word per clock while ready is high; its result lands in the output
// register on the same edge, or in the skid register when the output is stalled.
// The queue lives in a RAM whose read port is always aimed at the next head
// entry, so the head byte is ready when a tick arrives; one bypass register covers
// a byte written in the same cycle the head address is issued.
// Ready drops only when both the output register and the skid register hold results.
// Reset is asynchronous and active low; the queue contents need no clearing.
`default_nettype none
`include "keystroke_inject_queue_top_macros.svh"

module keystroke_inject_queue_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input words.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [kiq_pkg::IN_TDATA_W-1:0]       s_tdata,   // byte_in[7:0]
    input  wire logic [0:0]                           s_tuser,   // op
    // Result words.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [kiq_pkg::OUT_TDATA_W-1:0]      m_tdata,   // key_held, key_code[5:0],
                                                                 // shift_held, dropped
    // Configuration writes.
    input  wire logic                                 cfg_we,
    input  wire logic [kiq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [kiq_pkg::FRAME_W-1:0]          cfg_data
);

    // Queue pointers: the ring keeps one entry free to tell full from empty.
    logic [kiq_pkg::PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [kiq_pkg::PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;

    // Key state and frame timer.
    logic                        held_valid_reg, held_valid_next;
    logic [kiq_pkg::CODE_W-1:0]  held_code_reg, held_code_next;
    logic                        held_shift_reg, held_shift_next;
    logic [kiq_pkg::FRAME_W-1:0] frame_timer_reg, frame_timer_next;
    logic                        in_gap_reg, in_gap_next;

    // Configuration registers.
    logic [kiq_pkg::FRAME_W-1:0] hold_frames_reg;
    logic [kiq_pkg::FRAME_W-1:0] gap_frames_reg;

    // Head byte bypass for a write that collides with the head read address.
    logic                        byp_valid_reg;
    logic [kiq_pkg::BYTE_W-1:0]  byp_data_reg;

    logic                        s_accept;
    logic                        q_empty;
    logic                        q_full;
    logic                        ram_we;
    logic [kiq_pkg::BYTE_W-1:0]  ram_rdata;
    logic [kiq_pkg::BYTE_W-1:0]  head_byte;
    kiq_pkg::key_map_t           head_map;
    logic                        drop;
    kiq_pkg::result_t            result;
    kiq_pkg::result_t            out_data;
    logic                        res_ready;

    // Terms used by the checks at the end of the module.
    logic                        key_clear;
    logic                        tick_busy;
    logic [kiq_pkg::CODE_W:0]    key_state;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = res_ready;
    assign q_empty   = (rd_ptr_reg == wr_ptr_reg);
    assign q_full    = (kiq_pkg::ptr_inc(wr_ptr_reg) == rd_ptr_reg);
    assign head_byte = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign head_map  = kiq_pkg::key_rom(head_byte);

    // Next state for one accepted word.
    always_comb
    begin
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        held_valid_next  = held_valid_reg;
        held_code_next   = held_code_reg;
        held_shift_next  = held_shift_reg;
        frame_timer_next = frame_timer_reg;
        in_gap_next      = in_gap_reg;
        ram_we           = 1'b0;
        drop             = 1'b0;
        if (s_accept)
        begin
            if (s_tuser[0] == kiq_pkg::OP_PUSH)
            begin
                if (q_full)
                begin
                    drop = 1'b1;
                end
                else
                begin
                    ram_we      = 1'b1;
                    wr_ptr_next = kiq_pkg::ptr_inc(wr_ptr_reg);
                end
            end
            else
            begin
                priority if (frame_timer_reg != '0)
                begin
                    frame_timer_next = kiq_pkg::FRAME_W'(frame_timer_reg - 1'b1);
                end
                else if (!in_gap_reg && held_valid_reg)
                begin
                    // Hold time is over: release the key and start the gap.
                    held_valid_next  = 1'b0;
                    held_code_next   = '0;
                    held_shift_next  = 1'b0;
                    in_gap_next      = 1'b1;
                    frame_timer_next = gap_frames_reg;
                end
                else
                begin
                    in_gap_next = 1'b0;
                    if (!q_empty)
                    begin
                        // Unsupported bytes are consumed without a key press.
                        rd_ptr_next = kiq_pkg::ptr_inc(rd_ptr_reg);
                        if (head_map.valid)
                        begin
                            held_valid_next  = 1'b1;
                            held_code_next   = head_map.code;
                            held_shift_next  = head_map.shift;
                            frame_timer_next = hold_frames_reg;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        result.key_held   = held_valid_next;
        result.key_code   = held_valid_next ? held_code_next : '0;
        result.shift_held = held_valid_next && held_shift_next;
        result.dropped    = drop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            held_valid_reg  <= 1'b0;
            held_code_reg   <= '0;
            held_shift_reg  <= 1'b0;
            frame_timer_reg <= '0;
            in_gap_reg      <= 1'b0;
            byp_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            held_valid_reg  <= held_valid_next;
            held_code_reg   <= held_code_next;
            held_shift_reg  <= held_shift_next;
            frame_timer_reg <= frame_timer_next;
            in_gap_reg      <= in_gap_next;
            byp_valid_reg   <= ram_we && (wr_ptr_reg == rd_ptr_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_frames_reg <= kiq_pkg::HOLD_FRAMES_RESET;
            gap_frames_reg  <= kiq_pkg::GAP_FRAMES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kiq_pkg::CFG_HOLD_FRAMES: hold_frames_reg <= cfg_data;
                kiq_pkg::CFG_GAP_FRAMES:  gap_frames_reg  <= cfg_data;
            endcase
        end
    end

    // The read address follows the next head pointer so the data is ready in the next cycle.
    kiq_ram #(
        .WIDTH (kiq_pkg::BYTE_W),
        .DEPTH (kiq_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (s_tdata),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    kiq_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_accept),
        .in_ready  (res_ready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = kiq_pkg::OUT_TDATA_W'(out_data);

    assign key_clear = (held_code_reg == '0) && !held_shift_reg;
    assign tick_busy = s_accept && (s_tuser[0] == kiq_pkg::OP_TICK) && (frame_timer_reg != '0);
    assign key_state = {held_valid_reg, held_code_reg};

    // A released key never leaves a stale code or shift behind.
    `KIQ_ASSERT_NOW(a_idle_key_clear, clk, rst_n, !held_valid_reg, key_clear)
    // A dropped byte leaves both queue pointers untouched.
    `KIQ_ASSERT_NEXT(a_drop_keeps_ptrs, clk, rst_n, drop, $stable(wr_ptr_reg) && $stable(rd_ptr_reg))
    // While the timer runs, a tick does not change the key state.
    `KIQ_ASSERT_NEXT(a_timer_holds_key, clk, rst_n, tick_busy, $stable(key_state))
    // Back-pressure only appears with a result waiting at the output.
    `KIQ_ASSERT_NOW(a_stall_has_result, clk, rst_n, !s_tready, m_tvalid)

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for keystroke_inject_queue_top: pushes bytes and frame ticks,
// predicts every key-state word and checks each one field by field.
// Depends on kiq_pkg and the keystroke_inject_queue_top RTL.
module testbench;
    import kiq_pkg::*;

    // Longest wait either side may insert before a word.
    localparam int STALL_MAX = 15;
    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_PHASES = 8;

    localparam result_t NO_KEY = '0;

    typedef struct {
        logic              op;
        logic [BYTE_W-1:0] data;
        bit                typed;   // row carries its own expected word
        result_t           want;
    } stim_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [FRAME_W-1:0]     cfg_data  = '0;

    keystroke_inject_queue_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // byte_in[7:0]
        .s_tuser   (s_tuser),     // op
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // key_held, key_code[5:0], shift_held, dropped
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Shadow copy of the keyboard injector: byte ring, pointers, held key and timers.
    logic [BYTE_W-1:0]  shadow_bytes [QUEUE_DEPTH];
    int                 head_ptr     = 0;
    int                 tail_ptr     = 0;
    logic               key_down     = 1'b0;
    logic [CODE_W-1:0]  key_now      = '0;
    logic               shift_now    = 1'b0;
    logic [FRAME_W-1:0] frames_left  = '0;
    logic               gap_phase    = 1'b0;
    logic [FRAME_W-1:0] hold_setting = HOLD_FRAMES_RESET;
    logic [FRAME_W-1:0] gap_setting  = GAP_FRAMES_RESET;

    // Key-state words still owed by the block, oldest first.
    result_t   awaited_keys [$];
    int        mismatches  = 0;
    int        quiet_cycles = 0;
    // When set, that side inserts no wait states until it flips back.
    bit        s_quiet = 1'b0;
    bit        m_quiet = 1'b0;
    stim_row_t directed_rows [DIRECTED_ROWS];

    function automatic result_t pressed(input logic [CODE_W-1:0] code, input logic shift);
        result_t r;
        r            = '0;
        r.key_held   = 1'b1;
        r.key_code   = code;
        r.shift_held = shift;
        return r;
    endfunction

    // Character to key translation: letters, digits, the shifted digit row and the
    // punctuation keys. Lower case letters and the upper symbols need shift.
    function automatic key_map_t lookup_key(input logic [BYTE_W-1:0] c);
        key_map_t k;
        k = '0;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            k.valid = 1'b1;
            k.code  = KC_A + CODE_W'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7a)
        begin
            k.valid = 1'b1;
            k.shift = 1'b1;
            k.code  = KC_A + CODE_W'(c - 8'h61);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            k.valid = 1'b1;
            k.code  = KC_0 + CODE_W'(c - 8'h30);
        end
        else if (c >= 8'h21 && c <= 8'h29)
        begin
            k.valid = 1'b1;
            k.shift = 1'b1;
            k.code  = KC_0 + CODE_W'(c - 8'h20);
        end
        else
        begin
            k.valid = 1'b1;
            case (c)
                8'h0a, 8'h0d: k.code = KC_RETURN;
                8'h1b: k.code = KC_ESC;
                8'h7f: k.code = KC_DEL;
                8'h20: k.code = KC_BLANK;
                8'h2d: k.code = KC_DASH;
                8'h2c: k.code = KC_COMMA;
                8'h2e: k.code = KC_PERIOD;
                8'h2f: k.code = KC_SLASH;
                8'h3a: k.code = KC_COLON;
                8'h3b: k.code = KC_SEMI;
                8'h3d: {k.shift, k.code} = {1'b1, KC_DASH};
                8'h3c: {k.shift, k.code} = {1'b1, KC_COMMA};
                8'h3e: {k.shift, k.code} = {1'b1, KC_PERIOD};
                8'h3f: {k.shift, k.code} = {1'b1, KC_SLASH};
                8'h2a: {k.shift, k.code} = {1'b1, KC_COLON};
                8'h2b: {k.shift, k.code} = {1'b1, KC_SEMI};
                8'h5e: {k.shift, k.code} = {1'b1, KC_6};
                default: k = '0;
            endcase
        end
        return k;
    endfunction

    // Applies one accepted word to the shadow state and returns the key state after it.
    function automatic result_t advance_keyboard(input logic op, input logic [BYTE_W-1:0] b);
        result_t           r;
        key_map_t          k;
        int                nxt;
        logic [BYTE_W-1:0] c;
        r = '0;
        if (op == OP_PUSH)
        begin
            // One slot always stays free, so a full ring drops the byte.
            nxt = (tail_ptr + 1) % QUEUE_DEPTH;
            if (nxt == head_ptr)
            begin
                r.dropped = 1'b1;
            end
            else
            begin
                shadow_bytes[tail_ptr] = b;
                tail_ptr = nxt;
            end
        end
        else if (frames_left != 0)
        begin
            frames_left = frames_left - 1'b1;
        end
        else if (!gap_phase && key_down)
        begin
            key_down    = 1'b0;
            key_now     = '0;
            shift_now   = 1'b0;
            gap_phase   = 1'b1;
            frames_left = gap_setting;
        end
        else
        begin
            gap_phase = 1'b0;
            if (head_ptr != tail_ptr)
            begin
                c = shadow_bytes[head_ptr];
                head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
                k = lookup_key(c);
                // High bytes and bytes without a key are consumed silently.
                if (!c[7] && k.valid)
                begin
                    key_down    = 1'b1;
                    key_now     = k.code;
                    shift_now   = k.shift;
                    frames_left = hold_setting;
                end
            end
        end
        r.key_held   = key_down;
        r.key_code   = key_down ? key_now : '0;
        r.shift_held = key_down & shift_now;
        return r;
    endfunction

    // Mostly printable text, some control keys, a share of high bytes and raw noise.
    function automatic logic [BYTE_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return BYTE_W'($urandom_range(8'h20, 8'h7f));
        end
        else if (roll < 72)
        begin
            case ($urandom_range(0, 2))
                0: return 8'h0a;
                1: return 8'h0d;
                default: return 8'h1b;
            endcase
        end
        else if (roll < 88)
        begin
            return BYTE_W'($urandom_range(8'h80, 8'hff));
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Sends one word after a random gap. A zero gap keeps tvalid high across words, so
    // tvalid never gets two assignments in one step. The expectation is queued at the
    // accepting edge, ahead of the earliest edge its result can be taken.
    task automatic send_word(input logic op, input logic [BYTE_W-1:0] b,
                             input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = s_quiet ? 0 : $urandom_range(0, STALL_MAX);
        if ($urandom_range(0, 39) == 0)
        begin
            s_quiet = !s_quiet;
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        do @(posedge clk); while (s_tready !== 1'b1);
        predicted = advance_keyboard(op, b);
        awaited_keys.push_back(typed ? want : predicted);
    endtask

    // Holds the sender off until every owed result has been taken, then lets the
    // output path drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_keys.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the hold count, then the gap count, on consecutive edges; only called while idle.
    task automatic program_frames(input logic [FRAME_W-1:0] hold, input logic [FRAME_W-1:0] gap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HOLD_FRAMES;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_index <= CFG_GAP_FRAMES;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_we <= 1'b0;
        hold_setting = hold;
        gap_setting  = gap;
    endtask

    // Result side: random back-pressure, then each taken word is compared with the
    // oldest expectation. Outputs are read at the edge, before any update lands.
    initial
    begin
        int      stall;
        result_t got;
        result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = m_quiet ? 0 : $urandom_range(0, STALL_MAX);
            if ($urandom_range(0, 39) == 0)
            begin
                m_quiet = !m_quiet;
            end
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (awaited_keys.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected word: held=%0d code=%0d shift=%0d drop=%0d",
                             got.key_held, got.key_code, got.shift_held, got.dropped);
                end
            end
            else
            begin
                want = awaited_keys.pop_front();
                if (got.key_held !== want.key_held || got.key_code !== want.key_code ||
                    got.shift_held !== want.shift_held || got.dropped !== want.dropped ||
                    m_tdata[OUT_TDATA_W-1:$bits(result_t)] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected held=%0d code=%0d shift=%0d drop=%0d",
                                 want.key_held, want.key_code, want.shift_held, want.dropped);
                        $display("          got      held=%0d code=%0d shift=%0d drop=%0d fill=%h",
                                 got.key_held, got.key_code, got.shift_held, got.dropped,
                                 m_tdata[OUT_TDATA_W-1:$bits(result_t)]);
                    end
                end
            end
        end
    end

    // A hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int             phase;
        int             n;
        int             items;
        int             tick_share;
        logic [FRAME_W-1:0] hold;
        logic [FRAME_W-1:0] gap;
        logic           op;

        // Directed part, run with the reset frame counts (hold three, gap one).
        // After a tick on an empty queue, bytes are queued: a letter, a lower case letter,
        // the byte extremes, the caret, a high byte, carriage return and delete. The ticks
        // then walk one key through load, hold, release and gap, and show that a high
        // byte and an unsupported byte are consumed without a press.
        directed_rows = '{
            '{OP_TICK, 8'hff, 1'b1, NO_KEY},               // tick with an empty queue
            '{OP_PUSH, 8'h41, 1'b1, NO_KEY},
            '{OP_PUSH, 8'h7a, 1'b1, NO_KEY},
            '{OP_PUSH, 8'hff, 1'b1, NO_KEY},
            '{OP_PUSH, 8'h00, 1'b1, NO_KEY},
            '{OP_PUSH, 8'h5e, 1'b1, NO_KEY},
            '{OP_PUSH, 8'h80, 1'b1, NO_KEY},
            '{OP_PUSH, 8'h0d, 1'b1, NO_KEY},
            '{OP_PUSH, 8'h7f, 1'b1, NO_KEY},
            '{OP_TICK, 8'h00, 1'b1, pressed(KC_A, 1'b0)},
            '{OP_TICK, 8'h55, 1'b0, NO_KEY},
            '{OP_TICK, 8'haa, 1'b0, NO_KEY},
            '{OP_TICK, 8'h00, 1'b0, NO_KEY},
            '{OP_TICK, 8'h00, 1'b1, NO_KEY},               // hold ran out: release
            '{OP_TICK, 8'h00, 1'b0, NO_KEY},
            '{OP_TICK, 8'h00, 1'b1, pressed(KC_A + 6'd25, 1'b1)},
            '{OP_TICK, 8'h00, 1'b0, NO_KEY},
            '{OP_TICK, 8'h00, 1'b0, NO_KEY},
            '{OP_TICK, 8'h00, 1'b0, NO_KEY},
            '{OP_TICK, 8'h00, 1'b1, NO_KEY},
            '{OP_TICK, 8'h00, 1'b0, NO_KEY},
            '{OP_TICK, 8'h00, 1'b1, NO_KEY},               // high byte skipped
            '{OP_TICK, 8'h00, 1'b1, NO_KEY},               // unsupported byte skipped
            '{OP_TICK, 8'h00, 1'b1, pressed(KC_6, 1'b1)}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_word(directed_rows[i].op, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, each under its own frame counts: both zero, both full scale,
        // the mixed extremes, then small random counts. The phases with a full-scale hold
        // are tick heavy so a long hold actually expires.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            items      = 215;
            tick_share = 55;
            case (phase)
                0: {hold, gap} = {8'd0, 8'd0};
                1: {hold, gap} = {8'd255, 8'd255};
                2: {hold, gap} = {8'd0, 8'd255};
                3: {hold, gap} = {8'd255, 8'd0};
                default:
                begin
                    hold = FRAME_W'($urandom_range(0, 6));
                    gap  = FRAME_W'($urandom_range(0, 6));
                end
            endcase
            if (hold == 8'd255)
            begin
                items      = 320;
                tick_share = 95;
            end
            program_frames(hold, gap);
            for (n = 0; n < items; n++)
            begin
                op = ($urandom_range(0, 99) < tick_share) ? OP_TICK : OP_PUSH;
                send_word(op, pick_byte(), 1'b0, NO_KEY);
                // Now and then the sender waits for the output side to catch up.
                if ($urandom_range(0, 99) == 0)
                begin
                    settle();
                end
            end
        end

        settle();
        repeat (12) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
